### rtl/umx_pkg.sv
package umx_pkg;

  // register file geometry
  localparam int NumRegs = 8;
  localparam int RegAw   = $clog2(NumRegs);

  // instruction word layout
  localparam int ImmBits = 25;
  localparam int RegALsb = 6;
  localparam int RegBLsb = 3;
  localparam int RegCLsb = 0;
  localparam int LoadALsb = ImmBits;

  // opcodes as they arrive on the op field
  localparam logic [3:0] OP_CMOV = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd3;
  localparam logic [3:0] OP_MUL  = 4'd4;
  localparam logic [3:0] OP_DIV  = 4'd5;
  localparam logic [3:0] OP_NAND = 4'd6;
  localparam logic [3:0] OP_HALT = 4'd7;
  localparam logic [3:0] OP_OUT  = 4'd10;
  localparam logic [3:0] OP_IN   = 4'd11;
  localparam logic [3:0] OP_LOAD = 4'd13;

  // result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_DIV0        = 2'd1;
  localparam logic [1:0] ST_OUTRANGE    = 2'd2;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

  // decoded operation class
  typedef enum logic [3:0] {
    K_CMOV,
    K_ADD,
    K_MUL,
    K_DIV,
    K_NAND,
    K_HALT,
    K_OUT,
    K_IN,
    K_LOAD,
    K_UNSUP
  } kind_e;

  // decoded command passed from front to back
  typedef struct packed {
    kind_e            kind;
    logic [RegAw-1:0] ra;   // destination register
    logic [RegAw-1:0] rb;
    logic [RegAw-1:0] rc;
    logic [31:0]      imm;  // load value or input value
  } cmd_t;

endpackage

### rtl/umx_front.sv
module umx_front import umx_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  op_i,
  input  logic [31:0] instruction_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_eof_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output cmd_t        q_cmd_o
);

  // accept whenever the queue has room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // classify the transaction and pull out register fields
  always_comb begin
    q_cmd_o.ra   = instruction_i[RegALsb +: RegAw];
    q_cmd_o.rb   = instruction_i[RegBLsb +: RegAw];
    q_cmd_o.rc   = instruction_i[RegCLsb +: RegAw];
    q_cmd_o.imm  = 32'(instruction_i[ImmBits-1:0]);
    q_cmd_o.kind = K_UNSUP;
    case (op_i)
      OP_CMOV: q_cmd_o.kind = K_CMOV;
      OP_ADD:  q_cmd_o.kind = K_ADD;
      OP_MUL:  q_cmd_o.kind = K_MUL;
      OP_DIV:  q_cmd_o.kind = K_DIV;
      OP_NAND: q_cmd_o.kind = K_NAND;
      OP_HALT: q_cmd_o.kind = K_HALT;
      OP_OUT:  q_cmd_o.kind = K_OUT;
      OP_IN: begin
        q_cmd_o.kind = K_IN;
        // input writes register c
        q_cmd_o.ra   = instruction_i[RegCLsb +: RegAw];
        q_cmd_o.imm  = in_eof_i ? '1 : 32'(in_byte_i);
      end
      OP_LOAD: begin
        q_cmd_o.kind = K_LOAD;
        q_cmd_o.ra   = instruction_i[LoadALsb +: RegAw];
      end
      default: q_cmd_o.kind = K_UNSUP;
    endcase
  end

endmodule

### rtl/umx_queue.sv
module umx_queue import umx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  cmd_t            slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o  = (count_q == (PtrW+1)'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");

endmodule

### rtl/umx_back.sv
module umx_back import umx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  cmd_t        q_head_i,
  output logic        q_pop_o,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        halted_o,
  output logic [1:0]  status_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_WB
  } state_e;

  localparam int DivStepW = $clog2(32);

  state_e              state_q;
  cmd_t                cmd_q;
  logic                halt_q;
  logic                wr_en_q;
  logic [31:0]         wr_data_q;   // also the quotient during division
  logic [31:0]         rem_q;
  logic [31:0]         divisor_q;
  logic [DivStepW-1:0] step_q;
  logic                set_halt_q;
  logic                ob_valid_q;
  logic [7:0]          ob_byte_q;
  logic [1:0]          st_q;
  logic                res_valid_q;
  logic                res_out_valid_q;
  logic [7:0]          res_byte_q;
  logic                res_halted_q;
  logic [1:0]          res_status_q;

  // register file with per-entry valid bits for the zero reset
  logic [31:0]      rf_mem [NumRegs];
  logic [NumRegs-1:0] rf_vld_q;
  logic [31:0]      b_q, c_q;
  logic             rf_we;

  logic out_free;
  assign out_free = !res_valid_q || !res_stall_i;
  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i;
  assign rf_we    = (state_q == S_WB) && out_free && wr_en_q;

  // register file read and write ports
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      b_q <= rf_vld_q[q_head_i.rb] ? rf_mem[q_head_i.rb] : '0;
      c_q <= rf_vld_q[q_head_i.rc] ? rf_mem[q_head_i.rc] : '0;
    end
    if (rf_we) begin
      rf_mem[cmd_q.ra] <= wr_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (rf_we) begin
      rf_vld_q[cmd_q.ra] <= 1'b1;
    end
  end

  // execute the operation on the fetched operands
  logic        ex_wr_en;
  logic [31:0] ex_data;
  logic        ex_halt;
  logic        ex_ob_valid;
  logic [7:0]  ex_ob_byte;
  logic [1:0]  ex_status;
  logic        ex_div;
  logic [63:0] ex_prod;

  assign ex_prod = b_q * c_q;

  always_comb begin
    ex_wr_en    = 1'b0;
    ex_data     = '0;
    ex_halt     = 1'b0;
    ex_ob_valid = 1'b0;
    ex_ob_byte  = '0;
    ex_status   = ST_OK;
    ex_div      = 1'b0;
    if (!halt_q) begin
      case (cmd_q.kind)
        K_CMOV: begin
          ex_wr_en = (c_q != '0);
          ex_data  = b_q;
        end
        K_ADD: begin
          ex_wr_en = 1'b1;
          ex_data  = b_q + c_q;
        end
        K_MUL: begin
          ex_wr_en = 1'b1;
          ex_data  = ex_prod[31:0];
        end
        K_DIV: begin
          if (c_q == '0) begin
            ex_status = ST_DIV0;
          end else begin
            ex_div = 1'b1;
          end
        end
        K_NAND: begin
          ex_wr_en = 1'b1;
          ex_data  = ~(b_q & c_q);
        end
        K_HALT: ex_halt = 1'b1;
        K_OUT: begin
          if (c_q[31:8] == '0) begin
            ex_ob_valid = 1'b1;
            ex_ob_byte  = c_q[7:0];
          end else begin
            ex_status = ST_OUTRANGE;
          end
        end
        K_IN, K_LOAD: begin
          ex_wr_en = 1'b1;
          ex_data  = cmd_q.imm;
        end
        default: ex_status = ST_UNSUPPORTED;
      endcase
    end
  end

  // one restoring division step: shift in the next dividend bit
  logic [32:0] dv_shift;
  logic [32:0] dv_trial;
  assign dv_shift = {rem_q, wr_data_q[31]};
  assign dv_trial = dv_shift - {1'b0, divisor_q};

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      cmd_q           <= '{kind: K_UNSUP, default: '0};
      halt_q          <= 1'b0;
      wr_en_q         <= 1'b0;
      wr_data_q       <= '0;
      rem_q           <= '0;
      divisor_q       <= '0;
      step_q          <= '0;
      set_halt_q      <= 1'b0;
      ob_valid_q      <= 1'b0;
      ob_byte_q       <= '0;
      st_q            <= ST_OK;
      res_valid_q     <= 1'b0;
      res_out_valid_q <= 1'b0;
      res_byte_q      <= '0;
      res_halted_q    <= 1'b0;
      res_status_q    <= ST_OK;
    end else begin
      // result taken and no new one posted this cycle
      if (res_valid_q && !res_stall_i && state_q != S_WB) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (q_pop_o) begin
            cmd_q   <= q_head_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          wr_en_q    <= ex_wr_en;
          wr_data_q  <= ex_div ? b_q : ex_data;
          set_halt_q <= ex_halt;
          ob_valid_q <= ex_ob_valid;
          ob_byte_q  <= ex_ob_byte;
          st_q       <= ex_status;
          rem_q      <= '0;
          divisor_q  <= c_q;
          step_q     <= '0;
          state_q    <= ex_div ? S_DIV : S_WB;
        end
        S_DIV: begin
          if (!dv_trial[32]) begin
            rem_q     <= dv_trial[31:0];
            wr_data_q <= {wr_data_q[30:0], 1'b1};
          end else begin
            rem_q     <= dv_shift[31:0];
            wr_data_q <= {wr_data_q[30:0], 1'b0};
          end
          step_q <= step_q + 1'b1;
          if (step_q == '1) begin
            wr_en_q <= 1'b1;
            state_q <= S_WB;
          end
        end
        S_WB: begin
          if (out_free) begin
            halt_q          <= halt_q | set_halt_q;
            res_valid_q     <= 1'b1;
            res_out_valid_q <= ob_valid_q;
            res_byte_q      <= ob_byte_q;
            res_halted_q    <= halt_q | set_halt_q;
            res_status_q    <= st_q;
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign out_valid_o = res_out_valid_q;
  assign out_byte_o  = res_byte_q;
  assign halted_o    = res_halted_q;
  assign status_o    = res_status_q;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt flag dropped");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> divisor_q != '0) else $error("divide by zero in divider");
  a_wb_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WB && out_free |=> res_valid_q && state_q == S_IDLE)
    else $error("write back did not post a result");

endmodule

### rtl/um_register_execute_unit.sv
// channel   valid / stall              payload
// input     in_valid_i / in_stall_o    op_i, instruction_i, in_byte_i, in_eof_i
// result    res_valid_o / res_stall_i  out_valid_o, out_byte_o, halted_o, status_o
//
// divide takes longer than the other operations (one quotient bit per cycle in
// the restoring divider), and any result stall adds to a transaction's time.
// a two-entry command queue lets the input side keep accepting while the
// back end works or the result register is stalled.
// reset clears the register file (through per-entry valid bits), halt flag,
// queue and result register; no clearing pass is needed.
module um_register_execute_unit import umx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  op_i,
  input  logic [31:0] instruction_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_eof_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        halted_o,
  output logic [1:0]  status_o
);

  logic q_push, q_pop, q_full, q_empty;
  cmd_t push_cmd, head_cmd;

  // decode and enqueue
  umx_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .instruction_i (instruction_i),
    .in_byte_i     (in_byte_i),
    .in_eof_i      (in_eof_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (push_cmd)
  );

  // command queue between front and back
  umx_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .pop_i      (q_pop),
    .head_o     (head_cmd),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // execute against the register file
  umx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head_cmd),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .halted_o    (halted_o),
    .status_o    (status_o)
  );

endmodule

### sim/um_register_execute_unit_test.sv
module um_register_execute_unit_test;
  import umx_pkg::*;

  // opcodes the block does not execute
  localparam logic [3:0] OP_INDEX    = 4'd1;
  localparam logic [3:0] OP_AMEND    = 4'd2;
  localparam logic [3:0] OP_ALLOC    = 4'd8;
  localparam logic [3:0] OP_ABANDON  = 4'd9;
  localparam logic [3:0] OP_LOADPROG = 4'd12;
  localparam logic [3:0] OP_RSVD14   = 4'd14;
  localparam logic [3:0] OP_RSVD15   = 4'd15;

  localparam logic [31:0] BYTE_LIMIT = 32'd256;
  localparam int HOLD_LEN       = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 60;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       halted;
    logic [1:0] status;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  op_i = '0;
  logic [31:0] instruction_i = '0;
  logic [7:0]  in_byte_i = '0;
  logic        in_eof_i = 1'b0;
  logic        res_valid_o;
  logic        res_stall_i = 1'b0;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        halted_o;
  logic [1:0]  status_o;

  // machine state mirrored by the testbench
  logic [31:0] shadow_regs [NumRegs];
  logic        shadow_halted;
  result_t     pending_results [$];

  int mismatches = 0;
  bit quiet = 1'b0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stuck_cycles = 0;

  um_register_execute_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .instruction_i (instruction_i),
    .in_byte_i     (in_byte_i),
    .in_eof_i      (in_eof_i),
    .res_valid_o   (res_valid_o),
    .res_stall_i   (res_stall_i),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .halted_o      (halted_o),
    .status_o      (status_o)
  );

  always #5 clk_i = ~clk_i;

  // execute one instruction on the shadow machine
  function automatic result_t execute_instr(input logic [3:0] op, input logic [31:0] word,
                                            input logic [7:0] byte_in, input logic eof);
    result_t          r;
    logic [RegAw-1:0] ra;
    logic [RegAw-1:0] rb;
    logic [RegAw-1:0] rc;
    logic [31:0]      vb;
    logic [31:0]      vc;
    r  = '0;
    ra = word[RegALsb +: RegAw];
    rb = word[RegBLsb +: RegAw];
    rc = word[RegCLsb +: RegAw];
    vb = shadow_regs[rb];
    vc = shadow_regs[rc];
    if (!shadow_halted) begin
      case (op)
        OP_CMOV: begin
          if (vc != '0) shadow_regs[ra] = vb;
        end
        OP_ADD:  shadow_regs[ra] = vb + vc;
        OP_MUL:  shadow_regs[ra] = vb * vc;
        OP_DIV: begin
          if (vc == '0) r.status = ST_DIV0;
          else shadow_regs[ra] = vb / vc;
        end
        OP_NAND: shadow_regs[ra] = ~(vb & vc);
        OP_HALT: shadow_halted = 1'b1;
        OP_OUT: begin
          if (vc < BYTE_LIMIT) begin
            r.out_valid = 1'b1;
            r.out_byte  = vc[7:0];
          end else begin
            r.status = ST_OUTRANGE;
          end
        end
        OP_IN:   shadow_regs[rc] = eof ? '1 : {24'd0, byte_in};
        OP_LOAD: shadow_regs[word[LoadALsb +: RegAw]] = {7'd0, word[ImmBits-1:0]};
        default: r.status = ST_UNSUPPORTED;
      endcase
    end
    r.halted = shadow_halted;
    return r;
  endfunction

  function automatic logic [31:0] abc_word(input int a, input int b, input int c);
    logic [31:0] w;
    w = $urandom;
    w[RegALsb +: RegAw] = RegAw'(a);
    w[RegBLsb +: RegAw] = RegAw'(b);
    w[RegCLsb +: RegAw] = RegAw'(c);
    return w;
  endfunction

  function automatic logic [31:0] load_word(input int a, input logic [ImmBits-1:0] value);
    logic [31:0] w;
    w = $urandom;
    w[LoadALsb +: RegAw] = RegAw'(a);
    w[ImmBits-1:0] = value;
    return w;
  endfunction

  function automatic logic [3:0] unsupported_op(input int idx);
    case (idx)
      0:       return OP_INDEX;
      1:       return OP_AMEND;
      2:       return OP_ALLOC;
      3:       return OP_ABANDON;
      4:       return OP_LOADPROG;
      5:       return OP_RSVD14;
      default: return OP_RSVD15;
    endcase
  endfunction

  // offer one transaction and wait until it is taken
  task automatic send_item(input logic [3:0] op, input logic [31:0] word,
                           input logic [7:0] byte_in, input logic eof);
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    instruction_i <= word;
    in_byte_i     <= byte_in;
    in_eof_i      <= eof;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(execute_instr(op, word, byte_in, eof));
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_load_extremes;
    send_item(OP_LOAD, load_word(1, '1), 8'($urandom), 1'b0);
    send_item(OP_LOAD, load_word(2, '0), 8'($urandom), 1'b1);
    send_item(OP_LOAD, load_word(3, 25'd1), 8'($urandom), 1'b0);
  endtask

  task automatic test_input;
    send_item(OP_IN, abc_word($urandom_range(7), $urandom_range(7), 4), 8'hFF, 1'b0);
    // end of stream loads all ones
    send_item(OP_IN, abc_word($urandom_range(7), $urandom_range(7), 5), 8'h00, 1'b1);
    send_item(OP_IN, abc_word($urandom_range(7), $urandom_range(7), 0), 8'h00, 1'b0);
  endtask

  task automatic test_arith;
    send_item(OP_ADD, abc_word(6, 5, 3), 8'($urandom), 1'b0);   // wraps to zero
    send_item(OP_MUL, abc_word(7, 5, 5), 8'($urandom), 1'b0);
    send_item(OP_MUL, abc_word(6, 1, 1), 8'($urandom), 1'b0);   // high half dropped
    send_item(OP_NAND, abc_word(0, 2, 2), 8'($urandom), 1'b0);
    send_item(OP_CMOV, abc_word(6, 1, 2), 8'($urandom), 1'b0);  // condition zero
    send_item(OP_CMOV, abc_word(6, 1, 3), 8'($urandom), 1'b0);
    send_item(OP_DIV, abc_word(7, 5, 4), 8'($urandom), 1'b0);
    send_item(OP_DIV, abc_word(7, 4, 2), 8'($urandom), 1'b0);   // divide by zero
    send_item(OP_DIV, abc_word(0, 0, 0), 8'($urandom), 1'b0);
  endtask

  task automatic test_output;
    send_item(OP_OUT, abc_word($urandom_range(7), $urandom_range(7), 4), 8'($urandom), 1'b0);
    send_item(OP_OUT, abc_word($urandom_range(7), $urandom_range(7), 3), 8'($urandom), 1'b0);
    send_item(OP_OUT, abc_word($urandom_range(7), $urandom_range(7), 2), 8'($urandom), 1'b0);
    // first value past a byte, then all ones
    send_item(OP_LOAD, load_word(2, 25'd256), 8'($urandom), 1'b0);
    send_item(OP_OUT, abc_word($urandom_range(7), $urandom_range(7), 2), 8'($urandom), 1'b0);
    send_item(OP_OUT, abc_word($urandom_range(7), $urandom_range(7), 5), 8'($urandom), 1'b0);
  endtask

  task automatic test_unsupported;
    for (int i = 0; i < 7; i++) begin
      send_item(unsupported_op(i), $urandom, 8'($urandom), 1'($urandom));
    end
  endtask

  // random instruction mix, never halting
  task automatic test_random(input int count);
    logic [3:0]  op;
    logic [31:0] word;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 10) op = OP_CMOV;
      else if (pick < 20) op = OP_ADD;
      else if (pick < 30) op = OP_MUL;
      else if (pick < 42) op = OP_DIV;
      else if (pick < 50) op = OP_NAND;
      else if (pick < 62) op = OP_OUT;
      else if (pick < 74) op = OP_IN;
      else if (pick < 92) op = OP_LOAD;
      else op = unsupported_op($urandom_range(6));
      word = $urandom;
      // small load values keep zero divisors and byte-range outputs coming
      if (op == OP_LOAD) begin
        case ($urandom_range(3))
          0:       word[ImmBits-1:0] = ImmBits'($urandom_range(3));
          1:       word[ImmBits-1:0] = ImmBits'($urandom_range(255));
          2:       word[ImmBits-1:0] = ImmBits'($urandom_range(511));
          default: ;
        endcase
      end
      send_item(op, word, 8'($urandom), $urandom_range(9) == 0);
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure;
    quiet = 1'b1;
    hold_requests++;
    test_random(30);
    wait (holds_served == hold_requests && hold_left == 0);
    quiet = 1'b0;
  endtask

  task automatic test_pause;
    drain();
    test_random(20);
  endtask

  // halt, then everything after it is ignored
  task automatic test_halt;
    send_item(OP_HALT, $urandom, 8'($urandom), 1'b0);
    test_random(8);
    send_item(OP_HALT, $urandom, 8'($urandom), 1'b1);
    send_item(OP_OUT, abc_word(0, 0, 3), 8'($urandom), 1'b0);
  endtask

  initial begin
    for (int i = 0; i < NumRegs; i++) shadow_regs[i] = '0;
    shadow_halted = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_load_extremes();
    test_input();
    test_arith();
    test_output();
    test_unsupported();
    test_random(400);
    quiet = 1'b1;
    test_random(200);
    quiet = 1'b0;
    test_backpressure();
    test_pause();
    test_random(330);
    test_halt();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[um_register_execute_unit] OK");
    end else begin
      $display("[um_register_execute_unit] ERROR");
    end
    $finish;
  end

  // receiver side stall: random idling plus requested long hold-offs
  always @(posedge clk_i) begin
    if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_LEN;
      res_stall_i  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      res_stall_i <= 1'b1;
    end else begin
      res_stall_i <= !quiet && ($urandom_range(99) < 9);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t seen;
    result_t want;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      seen = {out_valid_o, out_byte_o, halted_o, status_o};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction, actual %h", $time, seen);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (seen.out_valid !== want.out_valid) begin
          $display("%0t: out_valid expected %0d actual %0d", $time, want.out_valid,
                   seen.out_valid);
          mismatches++;
        end
        if (seen.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                   seen.out_byte);
          mismatches++;
        end
        if (seen.halted !== want.halted) begin
          $display("%0t: halted expected %0d actual %0d", $time, want.halted, seen.halted);
          mismatches++;
        end
        if (seen.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, seen.status);
          mismatches++;
        end
      end
    end
  end

  // end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (res_valid_o && !res_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, stuck_cycles);
        $display("[um_register_execute_unit] ERROR");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

endmodule
